@@ hw/rtl/tbbf_pkg.sv @@
// ----------------------------------------------------------------------------
// tbbf_pkg
// shared types, constants and helpers of the triangle bounding-box fill block
// ----------------------------------------------------------------------------
package tbbf_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int COORD_W    = 7;
	localparam int COL_W      = 6;
	localparam int EDGE_W     = 8;
	localparam int PROD_W     = 16;
	localparam int ACC_W      = 18;
	localparam int VTX_W      = 16;
	localparam int COLOR_W    = 32;
	localparam int MASK_W     = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] SIDE_RESET = CFG_DATA_W'(MAX_SIDE);

	typedef struct packed {
		logic signed [VTX_W-1:0] vertex1_x;
		logic signed [VTX_W-1:0] vertex1_y;
		logic signed [VTX_W-1:0] vertex2_x;
		logic signed [VTX_W-1:0] vertex2_y;
		logic signed [VTX_W-1:0] vertex3_x;
		logic signed [VTX_W-1:0] vertex3_y;
		logic [COLOR_W-1:0]      fill_color;
	} in_t;

	typedef struct packed {
		logic [COL_W-1:0]   column_x;
		logic [MASK_W-1:0]  row_mask;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_column;
	} out_t;

	typedef struct packed {
		logic load;
		logic setup1;
		logic setup2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_col;
	} status_t;

	// size register to usable side length
	function automatic logic [COORD_W-1:0] eff_side(logic [CFG_DATA_W-1:0] r);
		logic [COORD_W-1:0] s;
		if (r == '0)
			s = COORD_W'(1);
		else if (r > CFG_DATA_W'(MAX_SIDE))
			s = COORD_W'(MAX_SIDE);
		else
			s = COORD_W'(r);
		return s;
	endfunction

	// floor(side * (v + 1.0) / 2) in q1.14, saturated to 0..side
	function automatic logic [COORD_W-1:0] to_screen(logic signed [VTX_W-1:0] v,
		logic [COORD_W-1:0] side);
		logic signed [VTX_W:0] t;
		logic [VTX_W+COORD_W-1:0] prod;
		logic [COORD_W:0] s;
		logic [COORD_W-1:0] res;
		t = (VTX_W+1)'(v) + (VTX_W+1)'(16384);
		prod = (VTX_W+COORD_W)'(t[VTX_W-1:0]) * (VTX_W+COORD_W)'(side);
		s = prod[VTX_W+COORD_W-1:15];
		if (t <= 0)
			res = '0;
		else if (s > (COORD_W+1)'(side))
			res = side;
		else
			res = s[COORD_W-1:0];
		return res;
	endfunction

endpackage

@@ hw/rtl/tbbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbbf_ctrl
// sequencer: capture, two setup steps, then one column per cycle
// ----------------------------------------------------------------------------
module tbbf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tbbf_pkg::status_t  status,
	output tbbf_pkg::cmd_t     cmd,
	output logic               busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP1,
		ST_SETUP2,
		ST_COLUMN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_SETUP1;
			end
			ST_SETUP1: state_d = ST_SETUP2;
			ST_SETUP2: state_d = ST_COLUMN;
			ST_COLUMN: begin
				if (status.last_col)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.setup1 = (state_q == ST_SETUP1);
		cmd.setup2 = (state_q == ST_SETUP2);
		cmd.emit   = (state_q == ST_COLUMN);
	end

	assign busy = busy_q;

endmodule

@@ hw/rtl/tbbf_dp.sv @@
// ----------------------------------------------------------------------------
// tbbf_dp
// datapath: screen mapping, bounding box, edge terms and per-column row test
// ----------------------------------------------------------------------------
module tbbf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tbbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbbf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  tbbf_pkg::in_t                     triangle,
	input  tbbf_pkg::cmd_t                    cmd,
	output tbbf_pkg::status_t                 status,
	output tbbf_pkg::out_t                    result,
	output logic                              result_valid
);

	logic [tbbf_pkg::CFG_DATA_W-1:0] width_q, height_q;
	logic [tbbf_pkg::COORD_W-1:0]    w_eff, h_eff, w_lim, h_lim;

	logic [tbbf_pkg::COORD_W-1:0]    x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
	logic [tbbf_pkg::COLOR_W-1:0]    color_q;

	logic [tbbf_pkg::COL_W-1:0]      xmin_q, xmax_q, ymin_q, ymax_q, px_q;
	logic signed [tbbf_pkg::EDGE_W-1:0] a1_q, a2_q, b1_q, b2_q;
	logic signed [tbbf_pkg::ACC_W-1:0]  uz_q, cu_q, cv_q;

	logic [tbbf_pkg::COORD_W-1:0]    xmin_c, xmax_c, ymin_c, ymax_c;
	logic signed [tbbf_pkg::EDGE_W-1:0] a3_c, y1s;
	logic signed [tbbf_pkg::PROD_W-1:0] p_a1b2, p_a2b1, p_a2y1, p_a3b2, p_a3b1, p_a1y1;
	logic [tbbf_pkg::MASK_W-1:0]     mask_c;

	tbbf_pkg::out_t result_q;
	logic           valid_q;

	function automatic logic [tbbf_pkg::COORD_W-1:0] min3(
		logic [tbbf_pkg::COORD_W-1:0] a, logic [tbbf_pkg::COORD_W-1:0] b,
		logic [tbbf_pkg::COORD_W-1:0] c);
		logic [tbbf_pkg::COORD_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic [tbbf_pkg::COORD_W-1:0] max3(
		logic [tbbf_pkg::COORD_W-1:0] a, logic [tbbf_pkg::COORD_W-1:0] b,
		logic [tbbf_pkg::COORD_W-1:0] c);
		logic [tbbf_pkg::COORD_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic [tbbf_pkg::COORD_W-1:0] clamp(
		logic [tbbf_pkg::COORD_W-1:0] v, logic [tbbf_pkg::COORD_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tbbf_pkg::SIDE_RESET;
			height_q <= tbbf_pkg::SIDE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				tbbf_pkg::REG_TARGET_WIDTH:  width_q  <= cfg_data;
				tbbf_pkg::REG_TARGET_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = tbbf_pkg::eff_side(width_q);
	assign h_eff = tbbf_pkg::eff_side(height_q);
	assign w_lim = w_eff - tbbf_pkg::COORD_W'(1);
	assign h_lim = h_eff - tbbf_pkg::COORD_W'(1);

	// bounding box
	assign xmin_c = clamp(min3(x1_q, x2_q, x3_q), w_lim);
	assign xmax_c = clamp(max3(x1_q, x2_q, x3_q), w_lim);
	assign ymin_c = clamp(min3(y1_q, y2_q, y3_q), h_lim);
	assign ymax_c = clamp(max3(y1_q, y2_q, y3_q), h_lim);

	// edge terms at the first column
	assign a3_c   = $signed({1'b0, x1_q}) - $signed({2'b00, xmin_q});
	assign y1s    = $signed({1'b0, y1_q});
	assign p_a1b2 = a1_q * b2_q;
	assign p_a2b1 = a2_q * b1_q;
	assign p_a2y1 = a2_q * y1s;
	assign p_a3b2 = a3_c * b2_q;
	assign p_a3b1 = a3_c * b1_q;
	assign p_a1y1 = a1_q * y1s;

	// all rows of the current column tested side by side
	always_comb begin
		logic signed [tbbf_pkg::ACC_W-1:0] row, ux, uy, sum;
		logic [tbbf_pkg::COORD_W-1:0]      r7;
		logic                              in_box, hit;
		mask_c = '0;
		for (int r = 0; r < tbbf_pkg::MAX_SIDE; r++) begin
			row    = tbbf_pkg::ACC_W'(r);
			r7     = tbbf_pkg::COORD_W'(r);
			ux     = cu_q - tbbf_pkg::ACC_W'(a2_q) * row;
			uy     = cv_q + tbbf_pkg::ACC_W'(a1_q) * row;
			sum    = ux + uy;
			in_box = (r7 >= {1'b0, ymin_q}) && (r7 <= {1'b0, ymax_q});
			if (uz_q > 0)
				hit = (ux >= 0) && (uy >= 0) && (sum <= uz_q);
			else if (uz_q < 0)
				hit = (ux <= 0) && (uy <= 0) && (sum >= uz_q);
			else
				hit = 1'b0;
			mask_c[r] = in_box && hit;
		end
	end

	// held triangle and edge state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q    <= tbbf_pkg::to_screen(triangle.vertex1_x, w_eff);
			y1_q    <= tbbf_pkg::to_screen(triangle.vertex1_y, h_eff);
			x2_q    <= tbbf_pkg::to_screen(triangle.vertex2_x, w_eff);
			y2_q    <= tbbf_pkg::to_screen(triangle.vertex2_y, h_eff);
			x3_q    <= tbbf_pkg::to_screen(triangle.vertex3_x, w_eff);
			y3_q    <= tbbf_pkg::to_screen(triangle.vertex3_y, h_eff);
			color_q <= triangle.fill_color;
		end
		if (cmd.setup1) begin
			xmin_q <= xmin_c[tbbf_pkg::COL_W-1:0];
			xmax_q <= xmax_c[tbbf_pkg::COL_W-1:0];
			ymin_q <= ymin_c[tbbf_pkg::COL_W-1:0];
			ymax_q <= ymax_c[tbbf_pkg::COL_W-1:0];
			px_q   <= xmin_c[tbbf_pkg::COL_W-1:0];
			a1_q   <= $signed({1'b0, x3_q}) - $signed({1'b0, x1_q});
			a2_q   <= $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
			b1_q   <= $signed({1'b0, y3_q}) - $signed({1'b0, y1_q});
			b2_q   <= $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
		end
		if (cmd.setup2) begin
			uz_q <= tbbf_pkg::ACC_W'(p_a1b2) - tbbf_pkg::ACC_W'(p_a2b1);
			cu_q <= tbbf_pkg::ACC_W'(p_a2y1) - tbbf_pkg::ACC_W'(p_a3b2);
			cv_q <= tbbf_pkg::ACC_W'(p_a3b1) - tbbf_pkg::ACC_W'(p_a1y1);
		end
		if (cmd.emit) begin
			// step one column to the right
			px_q <= px_q + tbbf_pkg::COL_W'(1);
			cu_q <= cu_q + tbbf_pkg::ACC_W'(b2_q);
			cv_q <= cv_q - tbbf_pkg::ACC_W'(b1_q);
			result_q.column_x    <= px_q;
			result_q.row_mask    <= mask_c;
			result_q.pixel_color <= color_q;
			result_q.last_column <= status.last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= cmd.emit;
	end

	assign status.last_col = (px_q == xmax_q);
	assign result          = result_q;
	assign result_valid    = valid_q;

endmodule

@@ hw/rtl/triangle_bbox_barycentric_fill.sv @@
// ----------------------------------------------------------------------------
// triangle_bbox_barycentric_fill
// the first column beat follows the capture, the two setup steps and the registered
// row test of the first column; the columns then follow at one beat per cycle, for 1
// to 64 bounding-box columns, and start is ignored until the block is idle again
// results are strobed for one cycle each and the receiver cannot stall
// reset: asynchronous, active low; sizes return to 64, the block goes idle
// ----------------------------------------------------------------------------
module triangle_bbox_barycentric_fill (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tbbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbbf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              start,
	input  tbbf_pkg::in_t                     triangle,
	output logic                              busy,
	output logic                              result_valid,
	output tbbf_pkg::out_t                    result
);

	tbbf_pkg::cmd_t    cmd;
	tbbf_pkg::status_t status;

	tbbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tbbf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.triangle     (triangle),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

@@ hw/rtl/tbbf_chk.sv @@
// ----------------------------------------------------------------------------
// tbbf_chk
// port-level checks of the triangle fill block, bound to the top level
// ----------------------------------------------------------------------------
module tbbf_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              result_valid,
	input tbbf_pkg::out_t                    result
);

	// an accepted triangle keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted triangle");

	// every beat comes out of a busy block
	a_beat_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat while idle");

	// columns of one triangle come back to back in ascending order
	a_next_column: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_column) |=>
		(result_valid && (result.column_x ==
			tbbf_pkg::COL_W'($past(result.column_x) + tbbf_pkg::COL_W'(1)))))
		else $error("column sequence broken");

	// colour stays fixed across one triangle
	a_same_colour: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_column) |=> $stable(result.pixel_color))
		else $error("colour changed within a triangle");

	// setup of the next triangle leaves a gap after the last column
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_column) |=> !result_valid)
		else $error("beat directly after last column");

endmodule

bind triangle_bbox_barycentric_fill tbbf_chk u_tbbf_chk (.*);
